### rtl/core/sjf_hrrn_ready_queue_scheduler_top_assert.svh
// Assertion macros for the ready-queue scheduler checker.
`ifndef SJF_HRRN_READY_QUEUE_SCHEDULER_TOP_ASSERT_SVH
`define SJF_HRRN_READY_QUEUE_SCHEDULER_TOP_ASSERT_SVH

// Clocked assertion, disabled during reset.
`define SJFH_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SJFH_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/core/sjfh_pkg.sv
// Types and constants shared by the ready-queue scheduler modules.
`timescale 1ns / 1ps
package sjfh_pkg;

   localparam logic [1:0] CMD_ADD      = 2'd0;
   localparam logic [1:0] CMD_DISPATCH = 2'd1;
   localparam logic [1:0] CMD_REMOVE   = 2'd2;
   localparam logic [1:0] CMD_NOP      = 2'd3;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
   localparam logic [1:0] STAT_EMPTY    = 2'd3;

   localparam logic [1:0] MODE_SJF_PRE = 2'd0;
   localparam logic [1:0] MODE_SJF_NP  = 2'd1;

   localparam logic       REG_MODE  = 1'b0;
   localparam logic       REG_ALPHA = 1'b1;

   localparam logic [6:0] PCT_MAX = 7'd100;
   // floor(u / 25) = (u * EST_RECIP) >> EST_SHIFT for u < 2^30
   localparam logic [29:0] EST_RECIP = 30'd687194768;
   localparam int          EST_SHIFT = 34;

   typedef struct packed {
      logic [15:0] id;
      logic [23:0] est;
      logic [15:0] wait_cnt;
      logic [15:0] burst;
   } entry_type;

   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_LOAD  = 3'd1,
      OP_DISP  = 3'd2,
      OP_SHIFT = 3'd3,
      OP_MUL   = 3'd4,
      OP_CMP   = 3'd5
   } op_type;

   typedef struct packed {
      op_type op;
      logic   parity;
      logic   start;
      logic   hrrn;
   } cell_ctrl_type;

endpackage

### rtl/core/sjfh_cell.sv
// One queue slot: holds an entry, compares with its left neighbor, swaps and shifts.
`timescale 1ns / 1ps
module sjfh_cell #(
   parameter int QUEUE_DEPTH = 16,
   parameter int INDEX       = 0
) (
   input  logic                         clock,
   input  sjfh_pkg::cell_ctrl_type      ctrl,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0] count,
   input  logic [$clog2(QUEUE_DEPTH)-1:0]   pos,
   input  sjfh_pkg::entry_type          new_entry,
   input  sjfh_pkg::entry_type          left_entry,
   input  sjfh_pkg::entry_type          right_entry,
   input  logic                         right_swap,
   output sjfh_pkg::entry_type          entry,
   output logic                         swap,
   output logic                         match
);

   sjfh_pkg::entry_type entry_ff, entry_in;
   logic [39:0] prod_mine_ff, prod_left_ff;
   logic [23:0] est_mine, est_left;
   logic        active, less;

   assign est_mine = (entry_ff.est == 24'd0) ? 24'd1 : entry_ff.est;
   assign est_left = (left_entry.est == 24'd0) ? 24'd1 : left_entry.est;

   assign active = (INDEX % 2 == int'(ctrl.parity)) && (INDEX > int'(ctrl.start))
                   && (INDEX < int'(count)) && (INDEX != 0);
   assign less   = ctrl.hrrn ? (prod_mine_ff > prod_left_ff)
                             : (entry_ff.est < left_entry.est);
   assign swap   = (ctrl.op == sjfh_pkg::OP_CMP) && active && less;
   assign match  = (entry_ff.id == new_entry.id) && (INDEX < int'(count));
   assign entry  = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         sjfh_pkg::OP_LOAD: begin
            if (INDEX == int'(pos)) entry_in = new_entry;
         end
         sjfh_pkg::OP_DISP: begin
            if (INDEX == 0) begin
               entry_in.wait_cnt = 16'd0;
               if (entry_ff.burst != 16'hFFFF) entry_in.burst = entry_ff.burst + 16'd1;
            end else if (entry_ff.wait_cnt != 16'hFFFF) begin
               entry_in.wait_cnt = entry_ff.wait_cnt + 16'd1;
            end
         end
         sjfh_pkg::OP_SHIFT: begin
            if (INDEX >= int'(pos)) entry_in = right_entry;
         end
         sjfh_pkg::OP_CMP: begin
            if (swap) entry_in = left_entry;
            else if (right_swap) entry_in = right_entry;
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (ctrl.op == sjfh_pkg::OP_MUL) begin
         prod_mine_ff <= 40'(entry_ff.wait_cnt) * 40'(est_left);
         prod_left_ff <= 40'(left_entry.wait_cnt) * 40'(est_mine);
      end
   end

endmodule

### rtl/core/sjf_hrrn_ready_queue_scheduler_top.sv
// Top level of the SJF / HRRN ready-queue scheduler.
`timescale 1ns / 1ps
// Ready-queue scheduler over a row of QUEUE_DEPTH slot cells. One command beat is
// taken at a time and answered by one response beat. An add runs the estimate
// arithmetic in EST1 and EST2, one load, then QUEUE_DEPTH odd-even transposition
// passes over the cell row, each a multiply step and a compare-and-swap step.
// Rejected commands answer straight from the idle state.
// The response register lets the next command start while a response waits.
module sjf_hrrn_ready_queue_scheduler_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // proc_id, last_estimate, last_burst
   input  logic [1:0]  req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // active_id, queue_count, status, pad
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [6:0]  csr_wdata
);

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_EST1  = 9'b000000010,
      ST_EST2  = 9'b000000100,
      ST_LOAD  = 9'b000001000,
      ST_MUL   = 9'b000010000,
      ST_CMP   = 9'b000100000,
      ST_DISP  = 9'b001000000,
      ST_FIND  = 9'b010000000,
      ST_SHIFT = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0]  mode_ff;
   logic [6:0]  alpha_ff;
   logic [CW-1:0] count_ff, count_in, pass_ff, pass_in;
   logic [IW-1:0] pos_ff, pos_in, pos_sel;
   logic        parity_ff, parity_in;
   logic        done_ff, done_in;
   logic [1:0]  status_ff, status_in;
   logic [15:0] id_ff, lest_ff, lb_ff;
   logic [22:0] sum_ff;
   logic [63:0] recip_ff;
   logic        rsp_valid_ff;
   logic [23:0] rsp_data_ff;

   logic [6:0]  a_sat;
   logic [29:0] p_prev, p_burst;
   logic [28:0] u_val;
   logic        found;
   logic [31:0] count32;

   sjfh_pkg::cell_ctrl_type ctrl;
   sjfh_pkg::entry_type     new_entry;
   sjfh_pkg::entry_type     cells [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]  swaps, hits;

   assign a_sat   = (alpha_ff > sjfh_pkg::PCT_MAX) ? sjfh_pkg::PCT_MAX : alpha_ff;
   assign p_prev  = 30'(a_sat) * 30'(lest_ff);
   assign p_burst = 30'(sjfh_pkg::PCT_MAX - a_sat) * 30'(lb_ff);
   assign u_val   = {sum_ff, 6'd0} + 29'd12;

   assign new_entry.id       = id_ff;
   assign new_entry.est      = recip_ff[sjfh_pkg::EST_SHIFT +: 24];
   assign new_entry.wait_cnt = 16'd0;
   assign new_entry.burst    = lb_ff;

   always_comb begin
      ctrl.parity = parity_ff;
      ctrl.start  = (mode_ff != sjfh_pkg::MODE_SJF_PRE);
      ctrl.hrrn   = mode_ff[1];
      unique case (state_ff)
         ST_LOAD:  ctrl.op = sjfh_pkg::OP_LOAD;
         ST_MUL:   ctrl.op = sjfh_pkg::OP_MUL;
         ST_CMP:   ctrl.op = sjfh_pkg::OP_CMP;
         ST_DISP:  ctrl.op = sjfh_pkg::OP_DISP;
         ST_SHIFT: ctrl.op = sjfh_pkg::OP_SHIFT;
         default:  ctrl.op = sjfh_pkg::OP_NONE;
      endcase
   end

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      sjfh_pkg::entry_type left_e, right_e;
      logic right_s;
      if (g == 0) begin : g_first
         assign left_e = '0;
      end else begin : g_left
         assign left_e = cells[g-1];
      end
      if (g == QUEUE_DEPTH - 1) begin : g_last
         assign right_e = '0;
         assign right_s = 1'b0;
      end else begin : g_right
         assign right_e = cells[g+1];
         assign right_s = swaps[g+1];
      end
      sjfh_cell #(.QUEUE_DEPTH(QUEUE_DEPTH), .INDEX(g)) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .count       (count_ff),
         .pos         (pos_ff),
         .new_entry   (new_entry),
         .left_entry  (left_e),
         .right_entry (right_e),
         .right_swap  (right_s),
         .entry       (cells[g]),
         .swap        (swaps[g]),
         .match       (hits[g])
      );
   end

   always_comb begin
      pos_sel = '0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (hits[i]) pos_sel = IW'(i);
      end
   end
   assign found = (|hits) && (id_ff != 16'd0);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pass_in   = pass_ff;
      pos_in    = pos_ff;
      parity_in = parity_ff;
      done_in   = 1'b0;
      status_in = status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               status_in = sjfh_pkg::STAT_OK;
               case (req_tuser)
                  sjfh_pkg::CMD_ADD: begin
                     if (req_tdata[15:0] == 16'd0) begin
                        status_in = sjfh_pkg::STAT_NOT_FOUND;
                        done_in   = 1'b1;
                     end else if (count_ff >= CW'(QUEUE_DEPTH)) begin
                        status_in = sjfh_pkg::STAT_FULL;
                        done_in   = 1'b1;
                     end else begin
                        state_in = ST_EST1;
                     end
                  end
                  sjfh_pkg::CMD_DISPATCH: begin
                     if (count_ff == '0) begin
                        status_in = sjfh_pkg::STAT_EMPTY;
                        done_in   = 1'b1;
                     end else begin
                        state_in = ST_DISP;
                     end
                  end
                  sjfh_pkg::CMD_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = sjfh_pkg::STAT_EMPTY;
                        done_in   = 1'b1;
                     end else begin
                        state_in = ST_FIND;
                     end
                  end
                  default: done_in = 1'b1;
               endcase
            end
         end
         ST_EST1: state_in = ST_EST2;
         ST_EST2: begin
            state_in = ST_LOAD;
            pos_in   = IW'(count_ff);
         end
         ST_LOAD: begin
            count_in  = count_ff + CW'(1);
            pass_in   = '0;
            parity_in = 1'b0;
            state_in  = ST_MUL;
         end
         ST_MUL: state_in = ST_CMP;
         ST_CMP: begin
            parity_in = ~parity_ff;
            pass_in   = pass_ff + CW'(1);
            if (pass_ff == CW'(QUEUE_DEPTH - 1)) begin
               state_in = ST_IDLE;
               done_in  = 1'b1;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_DISP: begin
            state_in = ST_IDLE;
            done_in  = 1'b1;
         end
         ST_FIND: begin
            if (found) begin
               pos_in   = pos_sel;
               state_in = ST_SHIFT;
            end else begin
               status_in = sjfh_pkg::STAT_NOT_FOUND;
               state_in  = ST_IDLE;
               done_in   = 1'b1;
            end
         end
         ST_SHIFT: begin
            count_in = count_ff - CW'(1);
            state_in = ST_IDLE;
            done_in  = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Busy outside the idle state and while a finished result waits to enter the response register.
   assign req_tready = (state_ff == ST_IDLE) && !done_ff;

   assign count32 = 32'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= sjfh_pkg::MODE_SJF_NP;
         alpha_ff     <= 7'd50;
         count_ff     <= '0;
         pass_ff      <= '0;
         parity_ff    <= 1'b0;
         done_ff      <= 1'b0;
         status_ff    <= sjfh_pkg::STAT_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         pass_ff   <= pass_in;
         parity_ff <= parity_in;
         status_ff <= status_in;
         if (csr_we) begin
            unique case (csr_addr)
               sjfh_pkg::REG_MODE:  mode_ff  <= csr_wdata[1:0];
               sjfh_pkg::REG_ALPHA: alpha_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (done_ff && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
            done_ff      <= done_in;
         end else begin
            if (rsp_tready) rsp_valid_ff <= 1'b0;
            done_ff <= done_ff | done_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (req_tvalid && req_tready) begin
         id_ff   <= req_tdata[15:0];
         lest_ff <= req_tdata[31:16];
         lb_ff   <= req_tdata[47:32];
      end
      if (state_ff == ST_EST1) sum_ff <= 23'(p_prev + p_burst);
      if (state_ff == ST_EST2) recip_ff <= 64'(u_val) * 64'(sjfh_pkg::EST_RECIP);
      if (done_ff && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {1'b0, status_ff, count32[4:0],
                         (count_ff == '0) ? 16'd0 : cells[0].id};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### rtl/core/sjfh_checker.sv
// Port-level checker for the ready-queue scheduler, bound to the top level.
`timescale 1ns / 1ps
`include "sjf_hrrn_ready_queue_scheduler_top_assert.svh"
module sjfh_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [47:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        csr_we,
   input logic        csr_addr,
   input logic [6:0]  csr_wdata
);

   logic [31:0] depth32;
   assign depth32 = 32'(QUEUE_DEPTH);

   `SJFH_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")
   `SJFH_ASSERT(a_empty_id, rsp_tvalid && rsp_tdata[20:16] == 5'd0 && depth32 < 32'd32 |-> rsp_tdata[15:0] == 16'd0, "empty queue reports a head id")
   `SJFH_ASSERT(a_empty_stat, rsp_tvalid && rsp_tdata[22:21] == sjfh_pkg::STAT_EMPTY |-> rsp_tdata[20:16] == 5'd0, "empty status with entries")
   `SJFH_ASSERT(a_full_stat, rsp_tvalid && rsp_tdata[22:21] == sjfh_pkg::STAT_FULL |-> rsp_tdata[20:16] == depth32[4:0], "full status below depth")
   `SJFH_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_tvalid, "response valid after reset")

endmodule

bind sjf_hrrn_ready_queue_scheduler_top sjfh_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_sjfh_checker (.*);

### tb/tb_sjf_hrrn_ready_queue_scheduler_top.sv
// Testbench for the SJF / HRRN ready-queue scheduler: directed table, then random beats.
`timescale 1ns / 1ps
module tb_sjf_hrrn_ready_queue_scheduler_top;

   localparam int DEPTH = 16;
   localparam int WATCHDOG = 20000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // proc_id, last_estimate, last_burst
   logic [1:0]  req_tuser;   // cmd
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // active_id, queue_count, status, pad
   logic        csr_we;
   logic        csr_addr;
   logic [6:0]  csr_wdata;

   typedef struct packed {
      logic [15:0] active_id;
      logic [4:0]  count;
      logic [1:0]  status;
   } reply_type;

   typedef struct {
      logic [1:0]  cmd;
      logic [15:0] pid;
      logic [15:0] lest;
      logic [15:0] lburst;
      logic        known;
      reply_type   reply;
   } row_type;

   // scheduler shadow
   logic [15:0] q_id [DEPTH];
   logic [23:0] q_est [DEPTH];
   logic [15:0] q_wait [DEPTH];
   logic [15:0] q_burst [DEPTH];
   int          q_len;
   logic [15:0] running_id;
   logic [1:0]  mode;
   logic [6:0]  alpha;

   reply_type   pending_replies[$];
   int          errors;
   int          idle_cycles;
   int          accepted;
   int          stall_phase;

   sjf_hrrn_ready_queue_scheduler_top #(.QUEUE_DEPTH(DEPTH)) DUT (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit ranks_ahead(int a, int b);
      logic [63:0] ea, eb;
      if (mode <= sjfh_pkg::MODE_SJF_NP) return q_est[a] < q_est[b];
      ea = (q_est[a] == 0) ? 64'd1 : 64'(q_est[a]);
      eb = (q_est[b] == 0) ? 64'd1 : 64'(q_est[b]);
      return 64'(q_wait[a]) * eb > 64'(q_wait[b]) * ea;
   endfunction

   function automatic void swap_entries(int a, int b);
      logic [15:0] ti;
      logic [23:0] te;
      ti = q_id[a]; q_id[a] = q_id[b]; q_id[b] = ti;
      te = q_est[a]; q_est[a] = q_est[b]; q_est[b] = te;
      ti = q_wait[a]; q_wait[a] = q_wait[b]; q_wait[b] = ti;
      ti = q_burst[a]; q_burst[a] = q_burst[b]; q_burst[b] = ti;
   endfunction

   function automatic reply_type schedule_step(logic [1:0] cmd, logic [15:0] pid,
                                               logic [15:0] lest, logic [15:0] lburst);
      reply_type r;
      logic [63:0] a, num;
      int pos, first, j;
      r.status = sjfh_pkg::STAT_OK;
      if (cmd == sjfh_pkg::CMD_ADD) begin
         if (pid == 0) r.status = sjfh_pkg::STAT_NOT_FOUND;
         else if (q_len >= DEPTH) r.status = sjfh_pkg::STAT_FULL;
         else begin
            a = (alpha > sjfh_pkg::PCT_MAX) ? 64'd100 : 64'(alpha);
            num = (a * lest + (64'd100 - a) * lburst) * 64'd256;
            q_id[q_len] = pid;
            q_est[q_len] = 24'((num + 64'd50) / 64'd100);
            q_wait[q_len] = 0;
            q_burst[q_len] = lburst;
            q_len++;
            first = (mode == sjfh_pkg::MODE_SJF_PRE) ? 0 : 1;
            for (int i = first + 1; i < q_len; i++) begin
               j = i;
               while (j > first && ranks_ahead(j, j - 1)) begin
                  swap_entries(j, j - 1);
                  j--;
               end
            end
         end
      end else if (cmd == sjfh_pkg::CMD_DISPATCH) begin
         if (q_len == 0) begin
            r.status = sjfh_pkg::STAT_EMPTY;
            running_id = 0;
         end else begin
            q_wait[0] = 0;
            if (q_burst[0] != 16'hFFFF) q_burst[0]++;
            for (int i = 1; i < q_len; i++)
               if (q_wait[i] != 16'hFFFF) q_wait[i]++;
            running_id = q_id[0];
         end
      end else if (cmd == sjfh_pkg::CMD_REMOVE) begin
         if (q_len == 0) r.status = sjfh_pkg::STAT_EMPTY;
         else begin
            pos = q_len;
            for (int i = 0; i < q_len; i++)
               if (pid != 0 && q_id[i] == pid) begin
                  pos = i;
                  break;
               end
            if (pos == q_len) r.status = sjfh_pkg::STAT_NOT_FOUND;
            else begin
               for (int i = pos; i + 1 < q_len; i++) begin
                  q_id[i] = q_id[i + 1]; q_est[i] = q_est[i + 1];
                  q_wait[i] = q_wait[i + 1]; q_burst[i] = q_burst[i + 1];
               end
               q_len--;
               if (pid == running_id) running_id = 0;
            end
         end
      end
      r.active_id = (q_len != 0) ? q_id[0] : 16'd0;
      r.count = 5'(q_len);
      return r;
   endfunction

   task automatic write_reg(logic idx, logic [6:0] val);
      @(negedge clock);
      csr_we <= 1'b1; csr_addr <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == sjfh_pkg::REG_MODE) mode = val[1:0]; else alpha = val;
   endtask

   task automatic drain_replies();
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   // drives one beat; expected result pushed at acceptance
   task automatic send_beat(row_type row);
      reply_type exp_r;
      req_tvalid <= 1'b1;
      req_tuser <= row.cmd;
      req_tdata <= {row.lburst, row.lest, row.pid};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      exp_r = schedule_step(row.cmd, row.pid, row.lest, row.lburst);
      if (row.known && exp_r !== row.reply) begin
         $display("%0t table row disagrees: exp %h got %h", $time, row.reply, exp_r);
         errors++;
      end
      pending_replies.push_back(row.known ? row.reply : exp_r);
      @(negedge clock);
   endtask

   function automatic row_type mk(logic [1:0] c, logic [15:0] p, logic [15:0] e,
                                  logic [15:0] b, logic k = 0,
                                  reply_type r = '0);
      row_type x;
      x.cmd = c; x.pid = p; x.lest = e; x.lburst = b; x.known = k; x.reply = r;
      return x;
   endfunction

   // receiver
   always @(posedge clock) begin
      reply_type got, want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[15:0], rsp_tdata[20:16], rsp_tdata[22:21]};
            if (pending_replies.size() == 0) begin
               $display("%0t unexpected reply: expected none actual %h", $time, got);
               errors++;
            end else begin
               want = pending_replies.pop_front();
               if (got.active_id !== want.active_id) begin
                  $display("%0t active_id: expected %h actual %h", $time,
                           want.active_id, got.active_id);
                  errors++;
               end
               if (got.count !== want.count) begin
                  $display("%0t queue_count: expected %0d actual %0d", $time,
                           want.count, got.count);
                  errors++;
               end
               if (got.status !== want.status) begin
                  $display("%0t status: expected %0d actual %0d", $time,
                           want.status, got.status);
                  errors++;
               end
            end
         end
         if (idle_cycles >= WATCHDOG) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      stall_phase <= stall_phase + 1;
      if (reset) rsp_tready <= 1'b0;
      else if (stall_phase[9:8] == 2'd3) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   initial begin
      row_type tbl[$];
      row_type row;
      int gap, burst_len, n, kind, pick;
      logic [15:0] ids[$];
      errors = 0; stall_phase = 0;
      q_len = 0; running_id = 0; mode = sjfh_pkg::MODE_SJF_NP; alpha = 7'd50;
      reset = 1'b1; req_tvalid = 1'b0; req_tdata = '0; req_tuser = '0;
      csr_we = 1'b0; csr_addr = 1'b0; csr_wdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      tbl.push_back(mk(sjfh_pkg::CMD_DISPATCH, 0, 0, 0, 1, '{0, 0, sjfh_pkg::STAT_EMPTY}));
      tbl.push_back(mk(sjfh_pkg::CMD_REMOVE, 5, 0, 0, 1, '{0, 0, sjfh_pkg::STAT_EMPTY}));
      tbl.push_back(mk(sjfh_pkg::CMD_ADD, 0, 9, 9, 1, '{0, 0, sjfh_pkg::STAT_NOT_FOUND}));
      tbl.push_back(mk(sjfh_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1,
                       '{16'hFFFF, 1, sjfh_pkg::STAT_OK}));
      tbl.push_back(mk(sjfh_pkg::CMD_ADD, 7, 0, 0));
      tbl.push_back(mk(sjfh_pkg::CMD_ADD, 7, 3, 1));
      tbl.push_back(mk(sjfh_pkg::CMD_REMOVE, 0, 0, 0, 1,
                       '{16'hFFFF, 3, sjfh_pkg::STAT_NOT_FOUND}));
      tbl.push_back(mk(sjfh_pkg::CMD_REMOVE, 1234, 0, 0, 1,
                       '{16'hFFFF, 3, sjfh_pkg::STAT_NOT_FOUND}));
      tbl.push_back(mk(sjfh_pkg::CMD_DISPATCH, 0, 0, 0));
      tbl.push_back(mk(sjfh_pkg::CMD_REMOVE, 16'hFFFF, 0, 0));
      tbl.push_back(mk(sjfh_pkg::CMD_NOP, 16'hAAAA, 16'h5555, 16'hAAAA));
      for (int i = 0; i < 16; i++)
         tbl.push_back(mk(sjfh_pkg::CMD_ADD, 16'(100 + i), 16'(i * 37), 16'(i)));
      foreach (tbl[i]) send_beat(tbl[i]);
      drain_replies();
      for (int i = 0; i < 16; i++) send_beat(mk(sjfh_pkg::CMD_REMOVE, 16'(q_id[0]), 0, 0));
      drain_replies();

      // several register settings, extremes included
      for (int phase = 0; phase < 8; phase++) begin
         write_reg(sjfh_pkg::REG_MODE, 7'(phase % 4));
         write_reg(sjfh_pkg::REG_ALPHA, (phase == 0) ? 7'd0 : (phase == 1) ? 7'd100 :
                   (phase == 2) ? 7'd127 : 7'($urandom_range(0, 127)));
         n = 0;
         while (n < 50) begin
            burst_len = $urandom_range(1, 8);
            for (int b = 0; b < burst_len && n < 50; b++) begin
               kind = $urandom_range(0, 9);
               row = mk(sjfh_pkg::CMD_ADD, 0, 16'($urandom), 16'($urandom));
               if (kind < 5) begin
                  row.cmd = sjfh_pkg::CMD_ADD;
                  row.pid = ($urandom_range(0, 15) == 0) ? 16'($urandom) :
                            16'($urandom_range(1, 24));
                  if ($urandom_range(0, 3) == 0) row.lest = 16'($urandom_range(0, 3));
               end else if (kind < 8) begin
                  row.cmd = sjfh_pkg::CMD_DISPATCH;
               end else begin
                  row.cmd = (kind == 9 && $urandom_range(0, 7) == 0) ?
                            sjfh_pkg::CMD_NOP : sjfh_pkg::CMD_REMOVE;
                  pick = $urandom_range(0, 3);
                  row.pid = (q_len != 0 && pick != 0) ?
                            q_id[$urandom_range(0, q_len - 1)] : 16'($urandom);
               end
               send_beat(row);
               n++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         drain_replies();
      end

      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/sjfh_pkg.sv
rtl/core/sjfh_cell.sv
rtl/core/sjf_hrrn_ready_queue_scheduler_top.sv
rtl/core/sjfh_checker.sv
tb/tb_sjf_hrrn_ready_queue_scheduler_top.sv
